>>> hw/rtl/lre_pkg.sv
`default_nettype none

package lre_pkg;

  // Default sizes of the stacks and of the arithmetic.
  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // The multiplier consumes this many bits of one operand per step.
  localparam int CHUNK_W = 8;

  // Fixed widths of the channel payloads.
  localparam int FUNC_W   = 3;
  localparam int NUM_W    = 32;
  localparam int STATUS_W = 2;
  localparam int RESULT_W = 32;
  localparam int STATE_W  = 4;

  // Token kinds.
  localparam logic [FUNC_W-1:0] TK_NUM   = 3'd0;
  localparam logic [FUNC_W-1:0] TK_PLUS  = 3'd1;
  localparam logic [FUNC_W-1:0] TK_TIMES = 3'd2;
  localparam logic [FUNC_W-1:0] TK_OPEN  = 3'd3;
  localparam logic [FUNC_W-1:0] TK_CLOSE = 3'd4;
  localparam logic [FUNC_W-1:0] TK_END   = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_PENDING  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ACCEPT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  // Parser states of the LR table.
  localparam logic [STATE_W-1:0] LR_S0 = 4'd0;
  localparam logic [STATE_W-1:0] LR_S1 = 4'd1;
  localparam logic [STATE_W-1:0] LR_S2 = 4'd2;
  localparam logic [STATE_W-1:0] LR_S3 = 4'd3;
  localparam logic [STATE_W-1:0] LR_S4 = 4'd4;
  localparam logic [STATE_W-1:0] LR_S5 = 4'd5;
  localparam logic [STATE_W-1:0] LR_S6 = 4'd6;
  localparam logic [STATE_W-1:0] LR_S7 = 4'd7;
  localparam logic [STATE_W-1:0] LR_S8 = 4'd8;
  localparam logic [STATE_W-1:0] LR_S9 = 4'd9;

  // Goto on E: the top bit says whether the state has an E entry at all.
  function automatic logic [STATE_W:0] goto_e(logic [STATE_W-1:0] s);
    logic [STATE_W:0] g;
    begin
      case (s)
        LR_S0:   g = {1'b1, LR_S1};
        LR_S2:   g = {1'b1, LR_S6};
        LR_S4:   g = {1'b1, LR_S7};
        LR_S5:   g = {1'b1, LR_S8};
        default: g = {1'b0, LR_S0};
      endcase
      return g;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lre_token_if.sv
`default_nettype none

interface lre_token_if;
  logic                         valid;
  logic                         ready;
  logic [lre_pkg::FUNC_W-1:0]   func;
  logic [lre_pkg::NUM_W-1:0]    number_value;

  modport source (output valid, output func, output number_value, input ready);
  modport sink (input valid, input func, input number_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lre_result_if.sv
`default_nettype none

interface lre_result_if;
  logic                           valid;
  logic                           ready;
  logic [lre_pkg::STATUS_W-1:0]   status;
  logic [lre_pkg::RESULT_W-1:0]   result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lr_expression_evaluator.sv
`default_nettype none

// LR evaluator for expressions over numbers, plus, times and parentheses, one token per
// transaction on tok and one result transaction on res for each token: pending, accepted with
// the value, syntax error, or stack overflow (the last three return the parser to its start
// state). The top of stack is held in registers and the entries below it in two stack RAMs. A
// shift, an accept or an error needs the token's acceptance and one sequencer step. A reduction
// that a token triggers reads the stack RAM, then takes the goto for a single number or a
// parenthesis, while an addition or a multiplication runs on one shared multiply-accumulate
// unit before its goto, taking 8 bits of an operand per cycle for a multiplication. A closing
// parenthesis or the end token can set off a chain of reductions as long as the stack is deep.
// The stacks need no clearing pass after reset.
// A finished result waits in an output register, and the next token is taken meanwhile.
module lr_expression_evaluator #(
  parameter int STACK_DEPTH = lre_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = lre_pkg::VALUE_WIDTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  lre_token_if.sink    tok,
  lre_result_if.source res
);

  localparam int SP_W      = $clog2(STACK_DEPTH);
  localparam int CHUNK_W   = lre_pkg::CHUNK_W;
  localparam int MUL_STEPS = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int CNT_W     = $clog2(MUL_STEPS + 1);
  localparam int STATE_W   = lre_pkg::STATE_W;
  localparam logic [SP_W:0] DEPTH_LIMIT = (SP_W + 1)'(STACK_DEPTH);

  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_DECIDE = 4'b0010,
    FSM_READ   = 4'b0100,
    FSM_ALU    = 4'b1000
  } fsm_t;

  typedef enum logic [1:0] {
    ACT_SHIFT,
    ACT_ACCEPT,
    ACT_ERROR,
    ACT_REDUCE
  } act_t;

  fsm_t fsm;

  // Parser stack: pointer and top entry in registers.
  logic [SP_W-1:0]        sp;
  logic [STATE_W-1:0]     top_state;
  logic [VALUE_WIDTH-1:0] top_value;

  // Current token.
  logic [lre_pkg::FUNC_W-1:0] tk;
  logic [lre_pkg::NUM_W-1:0]  num;

  // Shared multiply-accumulate unit.
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] opa;
  logic [VALUE_WIDTH-1:0] opb;
  logic [CNT_W-1:0]       cnt;
  logic                   is_mul;

  // Output register.
  logic                          out_valid;
  logic [lre_pkg::STATUS_W-1:0]  out_status;
  logic [lre_pkg::RESULT_W-1:0]  out_value;

  // Decoded action and its operands.
  act_t                   act;
  logic [STATE_W-1:0]     shift_state;
  logic [VALUE_WIDTH-1:0] shift_value;
  logic [SP_W:0]          sp_plus1;
  logic                   overflow;
  logic                   red_ok;
  logic [SP_W-1:0]        base_addr;
  logic [SP_W-1:0]        val_raddr;
  logic [SP_W-1:0]        red_sp;
  logic [STATE_W-1:0]     st_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic [STATE_W-1:0]     below_state;
  logic [STATE_W:0]       goto_res;
  logic                   goto_ok;
  logic                   is_binop;

  logic [VALUE_WIDTH+CHUNK_W-1:0] prod;
  logic [VALUE_WIDTH-1:0]         addend;
  logic [VALUE_WIDTH-1:0]         alu_sum;
  logic                           alu_done;

  logic                          out_free;
  logic                          finish;
  logic [lre_pkg::STATUS_W-1:0]  finish_status;
  logic                          do_clear;
  logic                          stk_we;
  logic [SP_W-1:0]               stk_addr;
  logic [STATE_W-1:0]            stk_state;
  logic [VALUE_WIDTH-1:0]        stk_value;
  logic [63:0]                   top_value_wide;

  assign tok.ready        = (fsm == FSM_IDLE);
  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.result_value = out_value;
  assign out_free         = !out_valid || res.ready;

  // Action table for the current top state and token.
  always_comb begin
    act         = ACT_ERROR;
    shift_state = lre_pkg::LR_S0;
    shift_value = '0;
    case (top_state) inside
      lre_pkg::LR_S0, lre_pkg::LR_S2, lre_pkg::LR_S4, lre_pkg::LR_S5: begin
        if (tk == lre_pkg::TK_NUM) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S3;
          shift_value = VALUE_WIDTH'(num);
        end else if (tk == lre_pkg::TK_OPEN) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S2;
        end
      end
      lre_pkg::LR_S1: begin
        if (tk == lre_pkg::TK_PLUS) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S4;
        end else if (tk == lre_pkg::TK_TIMES) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S5;
        end else if (tk == lre_pkg::TK_END) begin
          act = ACT_ACCEPT;
        end
      end
      lre_pkg::LR_S6: begin
        if (tk == lre_pkg::TK_PLUS) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S4;
        end else if (tk == lre_pkg::TK_TIMES) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S5;
        end else if (tk == lre_pkg::TK_CLOSE) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S9;
        end
      end
      lre_pkg::LR_S3, lre_pkg::LR_S7, lre_pkg::LR_S8, lre_pkg::LR_S9: begin
        if (top_state == lre_pkg::LR_S7 && tk == lre_pkg::TK_TIMES) begin
          act         = ACT_SHIFT;
          shift_state = lre_pkg::LR_S5;
        end else if (tk == lre_pkg::TK_PLUS || tk == lre_pkg::TK_TIMES ||
                     tk == lre_pkg::TK_CLOSE || tk == lre_pkg::TK_END) begin
          act = ACT_REDUCE;
        end
      end
      default: act = ACT_ERROR;
    endcase
  end

  // Stack arithmetic: overflow on shift, depth check and RAM addresses for a reduction.
  assign sp_plus1  = {1'b0, sp} + (SP_W + 1)'(1);
  assign overflow  = (sp_plus1 >= DEPTH_LIMIT);
  assign red_ok    = (top_state == lre_pkg::LR_S3) ? (sp != '0) : (sp >= SP_W'(3));
  assign base_addr = (top_state == lre_pkg::LR_S3) ? (sp - SP_W'(1)) : (sp - SP_W'(3));
  assign val_raddr = (top_state == lre_pkg::LR_S9) ? (sp - SP_W'(1)) : (sp - SP_W'(2));
  assign red_sp    = (top_state == lre_pkg::LR_S3) ? sp : (sp - SP_W'(2));
  assign is_binop  = (top_state == lre_pkg::LR_S7) || (top_state == lre_pkg::LR_S8);

  // Entry 0 is never written: it is read as the start state.
  assign below_state = (base_addr == '0) ? lre_pkg::LR_S0 : st_rdata;
  assign goto_res    = lre_pkg::goto_e(below_state);
  assign goto_ok     = goto_res[STATE_W];

  // Shared unit: one add, or one 8-bit slice of a multiplication, per cycle.
  assign prod     = opa * opb[CHUNK_W-1:0];
  assign addend   = is_mul ? prod[VALUE_WIDTH-1:0] : opa;
  assign alu_sum  = acc + addend;
  assign alu_done = (fsm == FSM_ALU) && (!is_mul || cnt == CNT_W'(1));

  // Completion of a token, its status and the return to the start state.
  always_comb begin
    finish        = 1'b0;
    finish_status = lre_pkg::STATUS_ERROR;
    do_clear      = 1'b0;
    if (fsm == FSM_DECIDE && out_free && !(act == ACT_REDUCE && red_ok)) begin
      finish = 1'b1;
      if (act == ACT_SHIFT) begin
        finish_status = overflow ? lre_pkg::STATUS_OVERFLOW : lre_pkg::STATUS_PENDING;
        do_clear      = overflow;
      end else if (act == ACT_ACCEPT) begin
        finish_status = lre_pkg::STATUS_ACCEPT;
        do_clear      = 1'b1;
      end else begin
        do_clear = 1'b1;
      end
    end else if (fsm == FSM_READ && !goto_ok && out_free) begin
      finish   = 1'b1;
      do_clear = 1'b1;
    end
  end

  // Stack writes: a shift, a direct goto, or a goto after the shared unit.
  always_comb begin
    stk_we    = 1'b0;
    stk_addr  = sp_plus1[SP_W-1:0];
    stk_state = shift_state;
    stk_value = shift_value;
    if (fsm == FSM_DECIDE && act == ACT_SHIFT && out_free && !overflow) begin
      stk_we = 1'b1;
    end else if (fsm == FSM_READ && goto_ok && !is_binop) begin
      stk_we    = 1'b1;
      stk_addr  = red_sp;
      stk_state = goto_res[STATE_W-1:0];
      stk_value = (top_state == lre_pkg::LR_S9) ? val_rdata : top_value;
    end else if (alu_done) begin
      stk_we    = 1'b1;
      stk_addr  = red_sp;
      stk_state = goto_res[STATE_W-1:0];
      stk_value = alu_sum;
    end
  end

  lre_ram #(
    .WIDTH (STATE_W),
    .DEPTH (STACK_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_addr),
    .wdata (stk_state),
    .raddr (base_addr),
    .rdata (st_rdata)
  );

  lre_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_addr),
    .wdata (stk_value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Sequencer, stack top and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= FSM_IDLE;
      sp        <= '0;
      top_state <= lre_pkg::LR_S0;
      top_value <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end
      if (do_clear) begin
        sp        <= '0;
        top_state <= lre_pkg::LR_S0;
        top_value <= '0;
      end else if (stk_we) begin
        sp        <= stk_addr;
        top_state <= stk_state;
        top_value <= stk_value;
      end
      unique case (fsm)
        FSM_IDLE: begin
          if (tok.valid) begin
            fsm <= FSM_DECIDE;
          end
        end
        FSM_DECIDE: begin
          if (finish) begin
            fsm <= FSM_IDLE;
          end else if (act == ACT_REDUCE && red_ok) begin
            fsm <= FSM_READ;
          end
        end
        FSM_READ: begin
          if (finish) begin
            fsm <= FSM_IDLE;
          end else if (goto_ok) begin
            fsm <= is_binop ? FSM_ALU : FSM_DECIDE;
          end
        end
        FSM_ALU: begin
          if (alu_done) begin
            fsm <= FSM_DECIDE;
          end
        end
        default: fsm <= FSM_IDLE;
      endcase
    end
  end

  assign top_value_wide = 64'(top_value);

  // Token capture, shared unit operands and result payload.
  always_ff @(posedge clk) begin
    if (tok.valid && tok.ready) begin
      tk  <= tok.func;
      num <= tok.number_value;
    end
    if (fsm == FSM_READ) begin
      acc    <= (top_state == lre_pkg::LR_S7) ? val_rdata : '0;
      opa    <= (top_state == lre_pkg::LR_S7) ? top_value : val_rdata;
      opb    <= top_value;
      is_mul <= (top_state == lre_pkg::LR_S8);
      cnt    <= CNT_W'(MUL_STEPS);
    end else if (fsm == FSM_ALU) begin
      acc <= alu_sum;
      opa <= opa << CHUNK_W;
      opb <= opb >> CHUNK_W;
      cnt <= cnt - CNT_W'(1);
    end
    if (finish) begin
      out_status <= finish_status;
      out_value  <= (finish_status == lre_pkg::STATUS_ACCEPT) ?
                    top_value_wide[lre_pkg::RESULT_W-1:0] : '0;
    end
  end

  // The stack pointer never passes the last entry.
  assert property (@(posedge clk) disable iff (rst)
    32'(sp) < STACK_DEPTH)
    else $error("stack pointer beyond the stack");

  // An empty stack always holds the start state on top.
  assert property (@(posedge clk) disable iff (rst)
    sp == '0 |-> top_state == lre_pkg::LR_S0)
    else $error("empty stack without start state");

  // Accept, error and overflow leave the parser in its start state.
  assert property (@(posedge clk) disable iff (rst)
    finish && finish_status != lre_pkg::STATUS_PENDING |=>
      sp == '0 && top_state == lre_pkg::LR_S0)
    else $error("stack not cleared after a final result");

  // Only an accepted expression carries a value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != lre_pkg::STATUS_ACCEPT |-> out_value == '0)
    else $error("value on a result that was not accepted");

endmodule

`default_nettype wire

>>> hw/rtl/lre_ram.sv
`default_nettype none

module lre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
